FILE: rtl/dmipi_pkg.sv
// Shared widths, constants, register map and types of the dual motor PI core.
package dmipi_pkg;

	// Field widths
	localparam int SPEED_W  = 16;
	localparam int MAG_W    = 15;
	localparam int TARGET_W = 15;
	localparam int GAIN_W   = 12;
	localparam int ERR_W    = 17;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int DRIVE_W  = 14;
	localparam int DUTY_W   = 13;

	// Fixed point of the gains and the width of the exact update sum
	localparam int GAIN_FRAC_BITS = 4;
	localparam int SUM_W          = 33;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

	// Drive clamp
	localparam int DRIVE_LIMIT = 8000;
	localparam logic signed [SUM_W-1:0] DRIVE_MAX = SUM_W'(DRIVE_LIMIT);
	localparam logic signed [SUM_W-1:0] DRIVE_MIN = -SUM_W'(DRIVE_LIMIT);

	// APB port
	localparam int PADDR_W = 5;
	localparam int DATA_W  = 32;

	typedef enum logic [2:0] {
		REG_TARGET_LEFT  = 3'd0,
		REG_TARGET_RIGHT = 3'd1,
		REG_KP_LEFT      = 3'd2,
		REG_KI_LEFT      = 3'd3,
		REG_KP_RIGHT     = 3'd4,
		REG_KI_RIGHT     = 3'd5,
		REG_STOP         = 3'd6
	} reg_idx_t;

	// Register reset values
	localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(30);
	localparam logic [GAIN_W-1:0]   KP_RST     = GAIN_W'(560);
	localparam logic [GAIN_W-1:0]   KI_RST     = GAIN_W'(400);
	localparam logic                STOP_RST   = 1'b1;

	// Settings of one motor loop
	typedef struct packed {
		logic [TARGET_W-1:0] target;
		logic [GAIN_W-1:0]   kp;
		logic [GAIN_W-1:0]   ki;
	} motor_cfg_t;

endpackage

FILE: rtl/dmipi_motor.sv
// One motor loop: error, incremental PI update, clamp, state and bridge split.
module dmipi_motor (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      advance,
	input  logic signed [dmipi_pkg::SPEED_W-1:0]      speed,
	input  dmipi_pkg::motor_cfg_t                     cfg,
	input  logic                                      stop,
	output logic signed [dmipi_pkg::DRIVE_W-1:0]      drive,
	output logic        [dmipi_pkg::DUTY_W-1:0]       duty_a,
	output logic        [dmipi_pkg::DUTY_W-1:0]       duty_b
);

	logic signed [dmipi_pkg::DRIVE_W-1:0]                 acc_q;
	logic signed [dmipi_pkg::ERR_W-1:0]                   prev_err_q;
	logic        [dmipi_pkg::MAG_W-1:0]                   mag;
	logic signed [dmipi_pkg::ERR_W-1:0]                   err;
	logic signed [dmipi_pkg::DIFF_W-1:0]                  diff;
	logic signed [dmipi_pkg::GAIN_W:0]                    kp_s;
	logic signed [dmipi_pkg::GAIN_W:0]                    ki_s;
	logic signed [dmipi_pkg::GAIN_W+dmipi_pkg::DIFF_W:0]  p_prod;
	logic signed [dmipi_pkg::GAIN_W+dmipi_pkg::ERR_W:0]   i_prod;
	logic signed [dmipi_pkg::SUM_W-1:0]                   total;
	logic signed [dmipi_pkg::SUM_W-1:0]                   quot;
	logic signed [dmipi_pkg::SUM_W-1:0]                   clamped;
	logic signed [dmipi_pkg::DRIVE_W-1:0]                 neg_drive;

	// Absolute speed, most negative count saturates
	always_comb begin
		if (speed == {1'b1, {(dmipi_pkg::SPEED_W-1){1'b0}}}) begin
			mag = {dmipi_pkg::MAG_W{1'b1}};
		end else if (speed[dmipi_pkg::SPEED_W-1]) begin
			mag = dmipi_pkg::MAG_W'(-speed);
		end else begin
			mag = dmipi_pkg::MAG_W'(speed);
		end
	end

	assign err  = $signed(dmipi_pkg::ERR_W'(cfg.target)) - $signed(dmipi_pkg::ERR_W'(mag));
	assign diff = dmipi_pkg::DIFF_W'(err) - dmipi_pkg::DIFF_W'(prev_err_q);

	assign kp_s   = $signed({1'b0, cfg.kp});
	assign ki_s   = $signed({1'b0, cfg.ki});
	assign p_prod = kp_s * diff;
	assign i_prod = ki_s * err;

	assign total = (dmipi_pkg::SUM_W'(acc_q) <<< dmipi_pkg::GAIN_FRAC_BITS)
	             + dmipi_pkg::SUM_W'(p_prod) + dmipi_pkg::SUM_W'(i_prod);

	// Truncate toward zero: bias negative sums before the arithmetic shift
	assign quot = (total + (total[dmipi_pkg::SUM_W-1] ? dmipi_pkg::ROUND_BIAS
	                                                  : dmipi_pkg::SUM_W'(0)))
	              >>> dmipi_pkg::GAIN_FRAC_BITS;

	always_comb begin
		priority if (stop) begin
			clamped = '0;
		end else if (quot < dmipi_pkg::DRIVE_MIN) begin
			clamped = dmipi_pkg::DRIVE_MIN;
		end else if (quot > dmipi_pkg::DRIVE_MAX) begin
			clamped = dmipi_pkg::DRIVE_MAX;
		end else begin
			clamped = quot;
		end
	end

	assign drive     = clamped[dmipi_pkg::DRIVE_W-1:0];
	assign neg_drive = -drive;
	assign duty_a    = drive[dmipi_pkg::DRIVE_W-1] ? neg_drive[dmipi_pkg::DUTY_W-1:0] : '0;
	assign duty_b    = drive[dmipi_pkg::DRIVE_W-1] ? '0 : drive[dmipi_pkg::DUTY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			prev_err_q <= '0;
		end else if (advance) begin
			acc_q      <= drive;
			prev_err_q <= err;
		end
	end

endmodule

FILE: rtl/dual_motor_incremental_pi_core.sv
// Top level of the dual motor incremental PI speed controller with bridge duty split.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  speed    | speed_valid / speed_stall | count_left, count_right (16 b signed)
//  drive    | drive_valid / drive_stall | drive_left/right (14 b signed),
//           |                           | duty_left_a/b, duty_right_a/b (13 b)
//  config   | APB psel/penable/pwrite   | paddr[4:0], pwdata/prdata (32 b)
//
// One transaction per cycle sustained while drive_stall is low; the accepted speed
// transaction passes the input register, then the result register, where drive_valid
// rises; a drive stall can hold it in between. The rate is set by the combinational
// PI update per motor, whose stored drive and last error feed the next tick.
// Reset clears both stored drives and last errors and loads the register defaults
// (targets 30, kp 35.0, ki 25.0, stop set). A stall on the drive side holds the
// result register; a tick held in the input register then holds too and speed_stall rises.
module dual_motor_incremental_pi_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// speed channel
	input  logic                                   speed_valid,
	output logic                                   speed_stall,
	input  logic signed [dmipi_pkg::SPEED_W-1:0]   count_left,
	input  logic signed [dmipi_pkg::SPEED_W-1:0]   count_right,
	// drive channel
	output logic                                   drive_valid,
	input  logic                                   drive_stall,
	output logic signed [dmipi_pkg::DRIVE_W-1:0]   drive_left,
	output logic signed [dmipi_pkg::DRIVE_W-1:0]   drive_right,
	output logic        [dmipi_pkg::DUTY_W-1:0]    duty_left_a,
	output logic        [dmipi_pkg::DUTY_W-1:0]    duty_left_b,
	output logic        [dmipi_pkg::DUTY_W-1:0]    duty_right_a,
	output logic        [dmipi_pkg::DUTY_W-1:0]    duty_right_b,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic        [dmipi_pkg::PADDR_W-1:0]   paddr,
	input  logic        [dmipi_pkg::DATA_W-1:0]    pwdata,
	output logic        [dmipi_pkg::DATA_W-1:0]    prdata,
	output logic                                   pready
);

	// ---------------- configuration registers ----------------
	dmipi_pkg::motor_cfg_t cfg_left_q;
	dmipi_pkg::motor_cfg_t cfg_right_q;
	logic                  stop_q;
	logic                  cfg_write;
	dmipi_pkg::reg_idx_t   reg_idx;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = dmipi_pkg::reg_idx_t'(paddr[dmipi_pkg::PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_left_q.target  <= dmipi_pkg::TARGET_RST;
			cfg_left_q.kp      <= dmipi_pkg::KP_RST;
			cfg_left_q.ki      <= dmipi_pkg::KI_RST;
			cfg_right_q.target <= dmipi_pkg::TARGET_RST;
			cfg_right_q.kp     <= dmipi_pkg::KP_RST;
			cfg_right_q.ki     <= dmipi_pkg::KI_RST;
			stop_q             <= dmipi_pkg::STOP_RST;
		end else if (cfg_write) begin
			// Drop writes to addresses past the last register
			unique case (reg_idx)
				dmipi_pkg::REG_TARGET_LEFT: begin
					cfg_left_q.target <= pwdata[dmipi_pkg::TARGET_W-1:0];
				end
				dmipi_pkg::REG_TARGET_RIGHT: begin
					cfg_right_q.target <= pwdata[dmipi_pkg::TARGET_W-1:0];
				end
				dmipi_pkg::REG_KP_LEFT: begin
					cfg_left_q.kp <= pwdata[dmipi_pkg::GAIN_W-1:0];
				end
				dmipi_pkg::REG_KI_LEFT: begin
					cfg_left_q.ki <= pwdata[dmipi_pkg::GAIN_W-1:0];
				end
				dmipi_pkg::REG_KP_RIGHT: begin
					cfg_right_q.kp <= pwdata[dmipi_pkg::GAIN_W-1:0];
				end
				dmipi_pkg::REG_KI_RIGHT: begin
					cfg_right_q.ki <= pwdata[dmipi_pkg::GAIN_W-1:0];
				end
				dmipi_pkg::REG_STOP: begin
					stop_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back; unmapped addresses read zero
	always_comb begin
		unique case (reg_idx)
			dmipi_pkg::REG_TARGET_LEFT:  prdata = dmipi_pkg::DATA_W'(cfg_left_q.target);
			dmipi_pkg::REG_TARGET_RIGHT: prdata = dmipi_pkg::DATA_W'(cfg_right_q.target);
			dmipi_pkg::REG_KP_LEFT:      prdata = dmipi_pkg::DATA_W'(cfg_left_q.kp);
			dmipi_pkg::REG_KI_LEFT:      prdata = dmipi_pkg::DATA_W'(cfg_left_q.ki);
			dmipi_pkg::REG_KP_RIGHT:     prdata = dmipi_pkg::DATA_W'(cfg_right_q.kp);
			dmipi_pkg::REG_KI_RIGHT:     prdata = dmipi_pkg::DATA_W'(cfg_right_q.ki);
			dmipi_pkg::REG_STOP:         prdata = dmipi_pkg::DATA_W'(stop_q);
			default:                     prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	logic                                 valid_s1;
	logic signed [dmipi_pkg::SPEED_W-1:0] count_left_s1;
	logic signed [dmipi_pkg::SPEED_W-1:0] count_right_s1;
	logic                                 drive_valid_q;
	logic                                 advance;
	logic                                 speed_accept;

	// Advance the held tick into the result register whenever that register frees up
	assign advance      = valid_s1 && (!drive_valid_q || !drive_stall);
	assign speed_stall  = valid_s1 && !advance;
	assign speed_accept = speed_valid && !speed_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!speed_stall) begin
			valid_s1 <= speed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (speed_accept) begin
			count_left_s1  <= count_left;
			count_right_s1 <= count_right;
		end
	end

	// ---------------- PI update per motor ----------------
	logic signed [dmipi_pkg::DRIVE_W-1:0] drive_left_nx;
	logic signed [dmipi_pkg::DRIVE_W-1:0] drive_right_nx;
	logic        [dmipi_pkg::DUTY_W-1:0]  duty_left_a_nx;
	logic        [dmipi_pkg::DUTY_W-1:0]  duty_left_b_nx;
	logic        [dmipi_pkg::DUTY_W-1:0]  duty_right_a_nx;
	logic        [dmipi_pkg::DUTY_W-1:0]  duty_right_b_nx;

	dmipi_motor u_motor_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.speed   (count_left_s1),
		.cfg     (cfg_left_q),
		.stop    (stop_q),
		.drive   (drive_left_nx),
		.duty_a  (duty_left_a_nx),
		.duty_b  (duty_left_b_nx)
	);

	dmipi_motor u_motor_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.speed   (count_right_s1),
		.cfg     (cfg_right_q),
		.stop    (stop_q),
		.drive   (drive_right_nx),
		.duty_a  (duty_right_a_nx),
		.duty_b  (duty_right_b_nx)
	);

	// ---------------- result register ----------------
	logic signed [dmipi_pkg::DRIVE_W-1:0] drive_left_q;
	logic signed [dmipi_pkg::DRIVE_W-1:0] drive_right_q;
	logic        [dmipi_pkg::DUTY_W-1:0]  duty_left_a_q;
	logic        [dmipi_pkg::DUTY_W-1:0]  duty_left_b_q;
	logic        [dmipi_pkg::DUTY_W-1:0]  duty_right_a_q;
	logic        [dmipi_pkg::DUTY_W-1:0]  duty_right_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (advance) begin
			drive_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_left_q   <= drive_left_nx;
			drive_right_q  <= drive_right_nx;
			duty_left_a_q  <= duty_left_a_nx;
			duty_left_b_q  <= duty_left_b_nx;
			duty_right_a_q <= duty_right_a_nx;
			duty_right_b_q <= duty_right_b_nx;
		end
	end

	assign drive_valid  = drive_valid_q;
	assign drive_left   = drive_left_q;
	assign drive_right  = drive_right_q;
	assign duty_left_a  = duty_left_a_q;
	assign duty_left_b  = duty_left_b_q;
	assign duty_right_a = duty_right_a_q;
	assign duty_right_b = duty_right_b_q;

	// ---------------- assertions ----------------
	// Reported drives stay inside the clamp
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid_q |-> (drive_left_q >= -dmipi_pkg::DRIVE_W'(dmipi_pkg::DRIVE_LIMIT))
		               && (drive_left_q <= dmipi_pkg::DRIVE_W'(dmipi_pkg::DRIVE_LIMIT))
		               && (drive_right_q >= -dmipi_pkg::DRIVE_W'(dmipi_pkg::DRIVE_LIMIT))
		               && (drive_right_q <= dmipi_pkg::DRIVE_W'(dmipi_pkg::DRIVE_LIMIT)))
		else $error("drive outside clamp");

	// Never drive both bridge sides at once
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid_q |-> ((duty_left_a_q == '0) || (duty_left_b_q == '0))
		               && ((duty_right_a_q == '0) || (duty_right_b_q == '0)))
		else $error("both bridge sides active");

	// A stopped block reports zero drive
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && stop_q) |=> (drive_left_q == '0) && (drive_right_q == '0))
		else $error("drive not zero under stop");

	// Only a held tick can back-pressure the speed side
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		speed_stall |-> valid_s1 && drive_valid_q && drive_stall)
		else $error("speed stall without a blocked result");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the dual motor incremental PI core: directed table, then random ticks.
`timescale 1ns / 100ps

module tb_top;

	localparam int REG_COUNT      = 7;
	localparam int UNMAPPED_REG   = 7;    // first register index past the map
	localparam int MAG_MAX        = (1 << dmipi_pkg::MAG_W) - 1;
	localparam int GAIN_MAX       = (1 << dmipi_pkg::GAIN_W) - 1;
	localparam int RANDOM_TICKS   = 1050;
	localparam int QUIET_TICKS    = 120;  // closing stretch with no idling on either side
	localparam int SETTLE_CYCLES  = 4;    // two-stage pipe plus margin
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIRECTED_ROWS  = 19;

	typedef int reg_set_t [REG_COUNT];

	typedef struct {
		logic signed [dmipi_pkg::DRIVE_W-1:0] drive_l;
		logic signed [dmipi_pkg::DRIVE_W-1:0] drive_r;
		logic        [dmipi_pkg::DUTY_W-1:0]  duty_la;
		logic        [dmipi_pkg::DUTY_W-1:0]  duty_lb;
		logic        [dmipi_pkg::DUTY_W-1:0]  duty_ra;
		logic        [dmipi_pkg::DUTY_W-1:0]  duty_rb;
	} drive_result_t;

	// One directed tick: register setting to use, speeds, and the result where it is obvious
	typedef struct {
		int setting;
		int spd_l;
		int spd_r;
		bit known;
		int dl;
		int dr;
		int la;
		int lb;
		int ra;
		int rb;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                   speed_valid = 1'b0;
	logic                                   speed_stall;
	logic signed [dmipi_pkg::SPEED_W-1:0]   count_left = '0;
	logic signed [dmipi_pkg::SPEED_W-1:0]   count_right = '0;
	logic                                   drive_valid;
	logic                                   drive_stall = 1'b0;
	logic signed [dmipi_pkg::DRIVE_W-1:0]   drive_left;
	logic signed [dmipi_pkg::DRIVE_W-1:0]   drive_right;
	logic        [dmipi_pkg::DUTY_W-1:0]    duty_left_a;
	logic        [dmipi_pkg::DUTY_W-1:0]    duty_left_b;
	logic        [dmipi_pkg::DUTY_W-1:0]    duty_right_a;
	logic        [dmipi_pkg::DUTY_W-1:0]    duty_right_b;
	logic                                   psel = 1'b0;
	logic                                   penable = 1'b0;
	logic                                   pwrite = 1'b0;
	logic        [dmipi_pkg::PADDR_W-1:0]   paddr = '0;
	logic        [dmipi_pkg::DATA_W-1:0]    pwdata = '0;
	logic        [dmipi_pkg::DATA_W-1:0]    prdata;
	logic                                   pready;

	dual_motor_incremental_pi_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.speed_valid  (speed_valid),
		.speed_stall  (speed_stall),
		.count_left   (count_left),
		.count_right  (count_right),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive_left   (drive_left),
		.drive_right  (drive_right),
		.duty_left_a  (duty_left_a),
		.duty_left_b  (duty_left_b),
		.duty_right_a (duty_right_a),
		.duty_right_b (duty_right_b),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the register file and of the loop state, as the core should hold them
	reg_set_t reg_shadow = '{int'(dmipi_pkg::TARGET_RST), int'(dmipi_pkg::TARGET_RST),
		int'(dmipi_pkg::KP_RST), int'(dmipi_pkg::KI_RST), int'(dmipi_pkg::KP_RST),
		int'(dmipi_pkg::KI_RST), int'(dmipi_pkg::STOP_RST)};
	int acc_drive [2] = '{0, 0};
	int last_err  [2] = '{0, 0};

	// Drive results predicted for accepted ticks, oldest first
	drive_result_t pending_drive [$];

	int gap_pct = 0;     // chance per tick of a sender idle burst
	int stall_pct = 0;   // chance per cycle of a receiver stall burst
	int mismatches = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int readbacks = 0;
	int settings_used = 0;
	int idle_cycles = 0;

	function automatic int reg_mask(int idx);
		case (idx)
			dmipi_pkg::REG_TARGET_LEFT, dmipi_pkg::REG_TARGET_RIGHT:
				return (1 << dmipi_pkg::TARGET_W) - 1;
			dmipi_pkg::REG_KP_LEFT, dmipi_pkg::REG_KI_LEFT, dmipi_pkg::REG_KP_RIGHT,
			dmipi_pkg::REG_KI_RIGHT:
				return GAIN_MAX;
			dmipi_pkg::REG_STOP:
				return 1;
			default:
				return 0;
		endcase
	endfunction

	// One motor's incremental PI update; advances the stored drive and last error
	function automatic int pi_motor(int m, int spd, int target, int kp, int ki);
		int     mag;
		int     err;
		longint total;
		longint d;
		mag = (spd < 0) ? -spd : spd;
		if (mag > MAG_MAX)
			mag = MAG_MAX;    // most negative count saturates
		err = target - mag;
		total = longint'(acc_drive[m]) * (longint'(1) << dmipi_pkg::GAIN_FRAC_BITS)
			+ longint'(kp) * longint'(err - last_err[m])
			+ longint'(ki) * longint'(err);
		d = total / (longint'(1) << dmipi_pkg::GAIN_FRAC_BITS);   // truncates toward zero
		last_err[m] = err;    // last error moves on even when stopped
		if (reg_shadow[dmipi_pkg::REG_STOP] != 0)
			d = 0;
		if (d > dmipi_pkg::DRIVE_LIMIT)
			d = dmipi_pkg::DRIVE_LIMIT;
		else if (d < -dmipi_pkg::DRIVE_LIMIT)
			d = -dmipi_pkg::DRIVE_LIMIT;
		acc_drive[m] = int'(d);
		return int'(d);
	endfunction

	// Both motors for one tick, with the bridge split: negative to side A, else side B
	function automatic drive_result_t pi_tick(int spd_l, int spd_r);
		drive_result_t res;
		int dl;
		int dr;
		dl = pi_motor(0, spd_l, reg_shadow[dmipi_pkg::REG_TARGET_LEFT],
			reg_shadow[dmipi_pkg::REG_KP_LEFT], reg_shadow[dmipi_pkg::REG_KI_LEFT]);
		dr = pi_motor(1, spd_r, reg_shadow[dmipi_pkg::REG_TARGET_RIGHT],
			reg_shadow[dmipi_pkg::REG_KP_RIGHT], reg_shadow[dmipi_pkg::REG_KI_RIGHT]);
		res.drive_l = dmipi_pkg::DRIVE_W'(dl);
		res.drive_r = dmipi_pkg::DRIVE_W'(dr);
		res.duty_la = (dl < 0) ? dmipi_pkg::DUTY_W'(-dl) : '0;
		res.duty_lb = (dl < 0) ? '0 : dmipi_pkg::DUTY_W'(dl);
		res.duty_ra = (dr < 0) ? dmipi_pkg::DUTY_W'(-dr) : '0;
		res.duty_rb = (dr < 0) ? '0 : dmipi_pkg::DUTY_W'(dr);
		return res;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Setting value: mostly a working range, sometimes anywhere, or an extreme
	function automatic int pick_value(bit extreme, int typical, int full);
		if (extreme)
			return $urandom_range(0, 1) ? full : 0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, full);
		return $urandom_range(0, typical);
	endfunction

	// Encoder count: mostly near the target in either direction, some noise and extremes
	function automatic int pick_speed(int target);
		int                                   r;
		int                                   noise;
		int                                   mag;
		logic signed [dmipi_pkg::SPEED_W-1:0] raw;
		r = $urandom_range(0, 99);
		if (r < 4)
			return $urandom_range(0, 1) ? -(MAG_MAX + 1) : MAG_MAX;
		if (r < 14) begin
			raw = dmipi_pkg::SPEED_W'($urandom);
			return int'(raw);
		end
		noise = 1 + target / 8;
		mag = target + $urandom_range(0, 2 * noise) - noise;
		if (mag < 0)
			mag = 0;
		if (mag > MAG_MAX)
			mag = MAG_MAX;
		return ($urandom_range(0, 3) == 0) ? -mag : mag;
	endfunction

	// APB write: setup, access, then idle; junk fills the bits above the register
	task automatic apb_write(int idx, int value);
		logic [dmipi_pkg::DATA_W-1:0] data;
		data = ($urandom & ~reg_mask(idx)) | (value & reg_mask(idx));
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= dmipi_pkg::PADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx < REG_COUNT)
			reg_shadow[idx] = data & reg_mask(idx);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(int idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= dmipi_pkg::PADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field($sformatf("prdata[reg %0d]", idx), dmipi_pkg::DATA_W'(reg_shadow[idx]),
			prdata);
		readbacks++;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Drain the pipe, then write the registers (all of them plus one unmapped address, or only
	// those that change) and read the whole map back
	task automatic program_loops(reg_set_t s, bit force_all);
		speed_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = 0; i < REG_COUNT; i++)
			if (force_all || s[i] != reg_shadow[i])
				apb_write(i, s[i]);
		if (force_all)
			apb_write(UNMAPPED_REG, $urandom);   // must land nowhere
		for (int i = 0; i < REG_COUNT; i++)
			apb_read_check(i);
		settings_used++;
	endtask

	// Offer one tick, maybe after an idle burst; hold the payload until it is taken
	task automatic send_tick(int spd_l, int spd_r, bit use_typed, drive_result_t typed);
		drive_result_t predicted;
		if ($urandom_range(0, 99) < gap_pct) begin
			speed_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		speed_valid <= 1'b1;
		count_left <= dmipi_pkg::SPEED_W'(spd_l);
		count_right <= dmipi_pkg::SPEED_W'(spd_r);
		do
			@(posedge clk);
		while (speed_stall);
		predicted = pi_tick(spd_l, spd_r);
		pending_drive.push_back(use_typed ? typed : predicted);
		ticks_sent++;
	endtask

	// Receiver stall: bursts at the rate the current phase asks
	always @(posedge clk) begin : stall_gen
		int left_over;
		if (!arst_n) begin
			drive_stall <= 1'b0;
			left_over = 0;
		end else if (left_over > 0) begin
			drive_stall <= 1'b1;
			left_over--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			drive_stall <= 1'b1;
			left_over = $urandom_range(0, 13);
		end else begin
			drive_stall <= 1'b0;
		end
	end

	// Compare each accepted drive transaction with the oldest prediction
	always @(posedge clk) begin : drive_check
		drive_result_t want;
		if (arst_n && drive_valid && !drive_stall) begin
			if (pending_drive.size() == 0) begin
				$error("drive transaction with no speed tick outstanding");
				mismatches++;
			end else begin
				want = pending_drive.pop_front();
				check_field("drive_left", want.drive_l, drive_left);
				check_field("drive_right", want.drive_r, drive_right);
				check_field("duty_left_a", want.duty_la, duty_left_a);
				check_field("duty_left_b", want.duty_lb, duty_left_b);
				check_field("duty_right_a", want.duty_ra, duty_right_a);
				check_field("duty_right_b", want.duty_rb, duty_right_b);
				results_checked++;
			end
		end
	end

	// Watchdog: end the run when no channel has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((speed_valid && !speed_stall) || (drive_valid && !drive_stall)
				|| (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", idle_cycles);
				$display("dual_motor_incremental_pi_core: mismatch");
				$finish;
			end
		end
	end

	initial begin : main
		reg_set_t      dir_set [6];
		directed_row_t script [DIRECTED_ROWS];
		drive_result_t typed;
		drive_result_t none;
		reg_set_t      s;
		int            cur_set;
		int            random_sent;
		int            left;
		int            n;
		bit            extreme;

		// Register settings of the directed part, in register order:
		// target_l, target_r, kp_l, ki_l, kp_r, ki_r, stop
		dir_set = '{
			'{30, 30, 560, 400, 560, 400, 1},          // reset values, stopped
			'{30, 30, 560, 400, 560, 400, 0},          // reset gains running
			'{0, 0, 4095, 4095, 4095, 4095, 0},        // gains at max, zero target
			'{32767, 32767, 0, 4095, 0, 4095, 0},      // target at max, integral only
			'{0, 0, 0, 1, 0, 1, 1},                    // tiny integral gain, stopped
			'{0, 0, 0, 1, 0, 1, 0}                     // tiny integral gain, running
		};

		// setting, left, right, known, drive l/r, duty la/lb/ra/rb
		script = '{
			// stopped: drives stay zero whatever the count, last errors still move
			'{0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
			'{0, 32767, 32767, 1, 0, 0, 0, 0, 0, 0},
			'{0, -32768, -32768, 1, 0, 0, 0, 0, 0, 0},
			'{0, -1, 1, 1, 0, 0, 0, 0, 0, 0},
			// reset gains at work
			'{1, 30, -30, 0, 0, 0, 0, 0, 0, 0},
			'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, -32768, 32767, 0, 0, 0, 0, 0, 0, 0},
			'{1, 100, -100, 0, 0, 0, 0, 0, 0, 0},
			// max gains drive both clamps; most negative count saturates
			'{2, 32767, 32767, 1, -8000, -8000, 8000, 0, 8000, 0},
			'{2, -32768, -32768, 1, -8000, -8000, 8000, 0, 8000, 0},
			'{2, 0, 0, 1, 8000, 8000, 0, 8000, 0, 8000},
			'{2, 0, -32768, 1, 8000, -8000, 0, 8000, 8000, 0},
			'{3, 0, 0, 1, 8000, 8000, 0, 8000, 0, 8000},
			'{3, 32767, -32768, 1, 8000, 8000, 0, 8000, 0, 8000},
			// stop again, then a small negative sum that must truncate toward zero
			'{4, 5, 5, 1, 0, 0, 0, 0, 0, 0},
			'{4, 7, -9, 1, 0, 0, 0, 0, 0, 0},
			'{5, 5, -5, 1, 0, 0, 0, 0, 0, 0},
			'{5, 20, 17, 0, 0, 0, 0, 0, 0, 0},
			'{5, -3, 3, 0, 0, 0, 0, 0, 0, 0}
		};

		none = '{default: '0};

		// Hold reset, then release it for good
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table with moderate idling on both sides
		gap_pct = 25;
		stall_pct = 25;
		cur_set = -1;
		foreach (script[i]) begin
			if (script[i].setting != cur_set) begin
				cur_set = script[i].setting;
				program_loops(dir_set[cur_set], 1'b0);
			end
			typed.drive_l = dmipi_pkg::DRIVE_W'(script[i].dl);
			typed.drive_r = dmipi_pkg::DRIVE_W'(script[i].dr);
			typed.duty_la = dmipi_pkg::DUTY_W'(script[i].la);
			typed.duty_lb = dmipi_pkg::DUTY_W'(script[i].lb);
			typed.duty_ra = dmipi_pkg::DUTY_W'(script[i].ra);
			typed.duty_rb = dmipi_pkg::DUTY_W'(script[i].rb);
			send_tick(script[i].spd_l, script[i].spd_r, script[i].known, typed);
		end

		// Random phases: fresh settings each phase, ticks that mostly track the targets
		random_sent = 0;
		while (random_sent < RANDOM_TICKS) begin
			left = RANDOM_TICKS - random_sent;
			extreme = ($urandom_range(0, 5) == 0);
			s[dmipi_pkg::REG_TARGET_LEFT]  = pick_value(extreme, 400, MAG_MAX);
			s[dmipi_pkg::REG_TARGET_RIGHT] = pick_value(extreme, 400, MAG_MAX);
			s[dmipi_pkg::REG_KP_LEFT]      = pick_value(extreme, 640, GAIN_MAX);
			s[dmipi_pkg::REG_KI_LEFT]      = pick_value(extreme, 480, GAIN_MAX);
			s[dmipi_pkg::REG_KP_RIGHT]     = pick_value(extreme, 640, GAIN_MAX);
			s[dmipi_pkg::REG_KI_RIGHT]     = pick_value(extreme, 480, GAIN_MAX);
			s[dmipi_pkg::REG_STOP]         = extreme ? $urandom_range(0, 1)
				: ($urandom_range(0, 5) == 0);
			program_loops(s, 1'b1);

			if (left <= QUIET_TICKS) begin
				// closing stretch: full rate, no stalls
				gap_pct = 0;
				stall_pct = 0;
				n = left;
			end else begin
				gap_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
				stall_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
				n = $urandom_range(40, 140);
				if (n > left - QUIET_TICKS)
					n = left - QUIET_TICKS;
			end
			repeat (n) begin
				send_tick(pick_speed(s[dmipi_pkg::REG_TARGET_LEFT]),
					pick_speed(s[dmipi_pkg::REG_TARGET_RIGHT]), 1'b0, none);
				random_sent++;
			end
		end

		// Drop valid, wait for the last drive results, then let the pipe settle
		speed_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);

		$display("Sent %0d speed ticks (%0d from the directed table) under %0d settings,",
			ticks_sent, DIRECTED_ROWS, settings_used);
		$display("checked %0d drive results and %0d register readbacks.",
			results_checked, readbacks);
		if (mismatches == 0)
			$display("dual_motor_incremental_pi_core: match");
		else
			$display("dual_motor_incremental_pi_core: mismatch");
		$finish;
	end

endmodule
